// ----- src/qte_pkg.sv -----
package qte_pkg;

   // Datapath widths
   localparam int SUM_W      = 35;  // doubled sums of products
   localparam int XY_W       = 36;  // CORDIC vector with growth headroom
   localparam int Z_W        = 32;  // angle accumulator, 29 fractional bits
   localparam int MAG_W      = 28;  // magnitude of the pitch sine term
   localparam int SQ_W       = 58;  // square root working width
   localparam int SQRT_STEPS = 29;  // one result bit per stage
   localparam int ATAN_LEN   = 24;

   localparam logic signed [SUM_W-1:0] ONE_Q28     = SUM_W'(64'sd268435456);
   localparam logic signed [Z_W-1:0]   HALF_PI_Q29 = 32'sd843314856;
   localparam logic signed [15:0]      HALF_PI_Q13 = 16'sd12868;

   typedef logic signed [SUM_W-1:0] sum_type;
   typedef logic signed [XY_W-1:0]  vec_type;
   typedef logic signed [Z_W-1:0]   ang_type;
   typedef logic [SQ_W-1:0]         sq_type;

   // atan(2^-i) scaled by 2^29
   function automatic ang_type atan_q29(input int idx);
      ang_type v;
      case (idx)
         0:       v = 32'sd421657428;
         1:       v = 32'sd248918915;
         2:       v = 32'sd131521918;
         3:       v = 32'sd66762579;
         4:       v = 32'sd33510843;
         5:       v = 32'sd16771758;
         6:       v = 32'sd8387925;
         7:       v = 32'sd4194219;
         8:       v = 32'sd2097141;
         9:       v = 32'sd1048575;
         10:      v = 32'sd524288;
         11:      v = 32'sd262144;
         12:      v = 32'sd131072;
         13:      v = 32'sd65536;
         14:      v = 32'sd32768;
         15:      v = 32'sd16384;
         16:      v = 32'sd8192;
         17:      v = 32'sd4096;
         18:      v = 32'sd2048;
         19:      v = 32'sd1024;
         20:      v = 32'sd512;
         21:      v = 32'sd256;
         22:      v = 32'sd128;
         23:      v = 32'sd64;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

// ----- src/qte_if.sv -----
interface qte_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] comp_a;
   logic signed [15:0] comp_b;
   logic signed [15:0] comp_c;
   logic signed [15:0] comp_d;
   modport source (output valid, comp_a, comp_b, comp_c, comp_d, input ready);
   modport sink   (input valid, comp_a, comp_b, comp_c, comp_d, output ready);
endinterface

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic               pitch_clamped;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clamped,
                   output ready);
endinterface

// ----- src/qte_cordic.sv -----
module qte_cordic #(
   parameter int STEPS = 16
) (
   input  logic                   clock,
   input  logic                   enable,
   input  qte_pkg::vec_type       vec_x,
   input  qte_pkg::vec_type       vec_y,
   output logic signed [15:0]     angle
);
   import qte_pkg::*;

   vec_type x_ff [STEPS+1];
   vec_type y_ff [STEPS+1];
   ang_type z_ff [STEPS+1];
   logic    zero_ff [STEPS+1];
   ang_type round_in;
   logic signed [15:0] angle_ff;

   // Pre-rotate into the right half plane
   always_ff @(posedge clock) begin
      if (enable) begin
         zero_ff[0] <= (vec_x == '0) && (vec_y == '0);
         if (vec_x[XY_W-1]) begin
            if (!vec_y[XY_W-1]) begin
               x_ff[0] <= vec_y;
               y_ff[0] <= -vec_x;
               z_ff[0] <= HALF_PI_Q29;
            end else begin
               x_ff[0] <= -vec_y;
               y_ff[0] <= vec_x;
               z_ff[0] <= -HALF_PI_Q29;
            end
         end else begin
            x_ff[0] <= vec_x;
            y_ff[0] <= vec_y;
            z_ff[0] <= '0;
         end
      end
   end

   // One micro-rotation per stage, driving y towards zero
   for (genvar i = 0; i < STEPS; i++) begin : g_iter
      always_ff @(posedge clock) begin
         if (enable) begin
            zero_ff[i+1] <= zero_ff[i];
            if (!y_ff[i][XY_W-1]) begin
               x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] + atan_q29(i);
            end else begin
               x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
               y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
               z_ff[i+1] <= z_ff[i] - atan_q29(i);
            end
         end
      end
   end

   // Round to Q3.13; a null vector gives zero
   assign round_in = z_ff[STEPS] + 32'sd32768;

   always_ff @(posedge clock) begin
      if (enable) begin
         angle_ff <= zero_ff[STEPS] ? 16'sd0 : round_in[31:16];
      end
   end

   assign angle = angle_ff;

endmodule

// ----- src/quaternion_to_euler_angles.sv -----
// Quaternion to Euler angles. Takes a quaternion (a, b, c, d) in signed Q2.14
// and returns roll = atan2(2(ab+cd), 1-2(b^2+c^2)), pitch = asin(2(ac-db)) and
// yaw = atan2(2(ad+bc), 1-2(c^2+d^2)) in signed Q3.13 radians. When the pitch
// sine term reaches magnitude one, pitch is clamped to +/-pi/2 and
// pitch_clamped is set. One quaternion is taken every cycle unless a stalled
// result holds the pipeline; each result passes through three product and
// sum stages, 29 square-root stages (one root bit each), a pre-rotation stage,
// CORDIC_STEPS CORDIC stages and a rounding stage. A stalled result holds the
// whole pipeline.
module quaternion_to_euler_angles #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic          clock,
   input  logic          reset,
   qte_req_if.sink       req_chan,
   qte_rsp_if.source     rsp_chan
);
   import qte_pkg::*;

   localparam int LAT = 3 + SQRT_STEPS + CORDIC_STEPS + 2;
   localparam int CL  = CORDIC_STEPS + 2;

   logic [LAT-1:0] vld_ff;
   logic           adv;

   // Stage 1: products
   logic signed [31:0] ab_ff, cd_ff, bb_ff, cc_ff, ac_ff, db_ff, ad_ff, bc_ff, dd_ff;
   // Stage 2: sums
   sum_type ry_ff, rx_ff, yy_ff, yx_ff, sp_ff;
   logic    clamp_ff, pos_ff;
   logic [MAG_W-1:0] mag_ff;
   sum_type mag_in;
   // Stage 3: square of the sine term
   sum_type ry3_ff, rx3_ff, yy3_ff, yx3_ff, sp3_ff;
   logic    clamp3_ff, pos3_ff;
   logic [2*MAG_W-1:0] msq_ff;
   // Square root stages
   sq_type  sqn_ff [SQRT_STEPS];
   sq_type  sqr_ff [SQRT_STEPS];
   sum_type qry_ff [SQRT_STEPS];
   sum_type qrx_ff [SQRT_STEPS];
   sum_type qyy_ff [SQRT_STEPS];
   sum_type qyx_ff [SQRT_STEPS];
   sum_type qsp_ff [SQRT_STEPS];
   logic    qcl_ff [SQRT_STEPS];
   logic    qps_ff [SQRT_STEPS];
   // Clamp flags alongside the CORDIC pipes
   logic [CL-1:0] ccl_ff, cps_ff;

   logic signed [15:0] roll_w, pitch_w, yaw_w;

   function automatic sum_type sp_in_f(input logic signed [31:0] p, input logic signed [31:0] q);
      return (SUM_W'(p) - SUM_W'(q)) <<< 1;
   endfunction

   assign adv          = !vld_ff[LAT-1] || rsp_chan.ready;
   assign req_chan.ready = adv;

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], req_chan.valid};
      end
   end

   // Form the products
   always_ff @(posedge clock) begin
      if (adv) begin
         ab_ff <= req_chan.comp_a * req_chan.comp_b;
         cd_ff <= req_chan.comp_c * req_chan.comp_d;
         bb_ff <= req_chan.comp_b * req_chan.comp_b;
         cc_ff <= req_chan.comp_c * req_chan.comp_c;
         ac_ff <= req_chan.comp_a * req_chan.comp_c;
         db_ff <= req_chan.comp_d * req_chan.comp_b;
         ad_ff <= req_chan.comp_a * req_chan.comp_d;
         bc_ff <= req_chan.comp_b * req_chan.comp_c;
         dd_ff <= req_chan.comp_d * req_chan.comp_d;
      end
   end

   // Combine into the CORDIC operands and test the pitch range
   always_comb begin
      mag_in = sp_in_f(ac_ff, db_ff);
      if (mag_in[SUM_W-1]) begin
         mag_in = -mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ry_ff    <= (SUM_W'(ab_ff) + SUM_W'(cd_ff)) <<< 1;
         rx_ff    <= ONE_Q28 - ((SUM_W'(bb_ff) + SUM_W'(cc_ff)) <<< 1);
         yy_ff    <= (SUM_W'(ad_ff) + SUM_W'(bc_ff)) <<< 1;
         yx_ff    <= ONE_Q28 - ((SUM_W'(cc_ff) + SUM_W'(dd_ff)) <<< 1);
         sp_ff    <= sp_in_f(ac_ff, db_ff);
         clamp_ff <= (sp_in_f(ac_ff, db_ff) >= ONE_Q28)
                     || (sp_in_f(ac_ff, db_ff) <= -ONE_Q28);
         pos_ff   <= sp_in_f(ac_ff, db_ff) > 0;
         mag_ff   <= mag_in[MAG_W-1:0];
      end
   end

   // Square the sine magnitude
   always_ff @(posedge clock) begin
      if (adv) begin
         ry3_ff    <= ry_ff;
         rx3_ff    <= rx_ff;
         yy3_ff    <= yy_ff;
         yx3_ff    <= yx_ff;
         sp3_ff    <= sp_ff;
         clamp3_ff <= clamp_ff;
         pos3_ff   <= pos_ff;
         msq_ff    <= mag_ff * mag_ff;
      end
   end

   // Cosine term: restoring square root, one result bit per stage
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      sq_type n_prev, r_prev, t_w, n_nxt, r_nxt;
      localparam sq_type BIT_K = sq_type'(1) << (2 * (SQRT_STEPS - 1 - k));
      if (k == 0) begin : g_first
         assign n_prev = (sq_type'(1) << 56) - sq_type'(msq_ff);
         assign r_prev = '0;
         always_ff @(posedge clock) begin
            if (adv) begin
               qry_ff[k] <= ry3_ff;
               qrx_ff[k] <= rx3_ff;
               qyy_ff[k] <= yy3_ff;
               qyx_ff[k] <= yx3_ff;
               qsp_ff[k] <= sp3_ff;
               qcl_ff[k] <= clamp3_ff;
               qps_ff[k] <= pos3_ff;
            end
         end
      end else begin : g_next
         assign n_prev = sqn_ff[k-1];
         assign r_prev = sqr_ff[k-1];
         always_ff @(posedge clock) begin
            if (adv) begin
               qry_ff[k] <= qry_ff[k-1];
               qrx_ff[k] <= qrx_ff[k-1];
               qyy_ff[k] <= qyy_ff[k-1];
               qyx_ff[k] <= qyx_ff[k-1];
               qsp_ff[k] <= qsp_ff[k-1];
               qcl_ff[k] <= qcl_ff[k-1];
               qps_ff[k] <= qps_ff[k-1];
            end
         end
      end
      assign t_w = r_prev + BIT_K;
      always_comb begin
         if (n_prev >= t_w) begin
            n_nxt = n_prev - t_w;
            r_nxt = (r_prev >> 1) + BIT_K;
         end else begin
            n_nxt = n_prev;
            r_nxt = r_prev >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            sqn_ff[k] <= n_nxt;
            sqr_ff[k] <= r_nxt;
         end
      end
   end

   // Three CORDIC pipes in lockstep
   qte_cordic #(.STEPS(CORDIC_STEPS)) u_roll (
      .clock  (clock),
      .enable (adv),
      .vec_x  (XY_W'(qrx_ff[SQRT_STEPS-1])),
      .vec_y  (XY_W'(qry_ff[SQRT_STEPS-1])),
      .angle  (roll_w)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_pitch (
      .clock  (clock),
      .enable (adv),
      .vec_x  (vec_type'({1'b0, sqr_ff[SQRT_STEPS-1][XY_W-2:0]})),
      .vec_y  (XY_W'(qsp_ff[SQRT_STEPS-1])),
      .angle  (pitch_w)
   );

   qte_cordic #(.STEPS(CORDIC_STEPS)) u_yaw (
      .clock  (clock),
      .enable (adv),
      .vec_x  (XY_W'(qyx_ff[SQRT_STEPS-1])),
      .vec_y  (XY_W'(qyy_ff[SQRT_STEPS-1])),
      .angle  (yaw_w)
   );

   // Hold the clamp flags level with the CORDIC pipes
   always_ff @(posedge clock) begin
      if (adv) begin
         ccl_ff <= {ccl_ff[CL-2:0], qcl_ff[SQRT_STEPS-1]};
         cps_ff <= {cps_ff[CL-2:0], qps_ff[SQRT_STEPS-1]};
      end
   end

   // Drive the result channel
   assign rsp_chan.valid         = vld_ff[LAT-1];
   assign rsp_chan.roll_angle    = roll_w;
   assign rsp_chan.yaw_angle     = yaw_w;
   assign rsp_chan.pitch_clamped = ccl_ff[CL-1];
   assign rsp_chan.pitch_angle   = ccl_ff[CL-1]
                                   ? (cps_ff[CL-1] ? HALF_PI_Q13 : -HALF_PI_Q13)
                                   : pitch_w;

`ifndef SYNTHESIS
   a_clamp_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.pitch_clamped) |->
         (rsp_chan.pitch_angle == HALF_PI_Q13 || rsp_chan.pitch_angle == -HALF_PI_Q13))
      else $error("clamped pitch is not a right angle");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while the pipeline is stalled");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(vld_ff)))
      else $error("pipeline moved during a stall");
`endif

endmodule

// ----- test/tb_quaternion_to_euler_angles.sv -----
`timescale 1ns / 100ps

module tb_quaternion_to_euler_angles;
   import qte_pkg::*;

   localparam int STEPS     = 16;
   localparam int LATENCY   = 34 + STEPS;
   localparam int N_RANDOM  = 1100;
   localparam longint LIMIT = 400000;

   typedef struct packed {
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
      logic signed [15:0] d;
   } quat_type;

   typedef struct packed {
      logic signed [15:0] roll;
      logic signed [15:0] pitch;
      logic signed [15:0] yaw;
      logic               clamped;
   } euler_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   qte_req_if req_chan ();
   qte_rsp_if rsp_chan ();

   quaternion_to_euler_angles #(.CORDIC_STEPS(STEPS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   quat_type  pending_quats[$];
   euler_type expected_angles[$];
   int     errors = 0;
   int     sent = 0;
   int     received = 0;
   int     clamp_count = 0;
   longint cycle = 0;
   bit     src_quiet = 1'b0;
   bit     sink_quiet = 1'b0;
   bit     hold_send = 1'b0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Arithmetic shift right that floors
   function automatic longint shr_floor(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, bitv;
      r = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= r + bitv) begin
            n -= r + bitv;
            r = (r >> 1) + bitv;
         end else begin
            r >>= 1;
         end
         bitv >>= 2;
      end
      return longint'(r);
   endfunction

   // Vectoring rotation; angle at 29 fractional bits
   function automatic longint vector_angle(longint y, longint x);
      longint z, t, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = HALF_PI_Q29;
         end else begin
            x = -y; y = t; z = -HALF_PI_Q29;
         end
      end
      for (int i = 0; i < STEPS && i < ATAN_LEN; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; z += atan_q29(i);
         end else begin
            x -= ys; y += xs; z -= atan_q29(i);
         end
      end
      return z;
   endfunction

   function automatic logic signed [15:0] round_q13(longint z);
      longint r;
      r = shr_floor(z + 32768, 16);
      return r[15:0];
   endfunction

   function automatic euler_type predict_euler(quat_type q);
      longint a, b, c, d, ry, rx, sp, yy, yx, one, cp;
      longint unsigned mag;
      euler_type e;
      a = q.a; b = q.b; c = q.c; d = q.d;
      one = 64'sd1 << 28;
      ry = 2 * (a * b + c * d);
      rx = one - 2 * (b * b + c * c);
      sp = 2 * (a * c - d * b);
      yy = 2 * (a * d + b * c);
      yx = one - 2 * (c * c + d * d);
      e.roll = round_q13(vector_angle(ry, rx));
      if (sp >= one || sp <= -one) begin
         e.pitch = (sp > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
         e.clamped = 1'b1;
      end else begin
         mag = (sp < 0) ? -sp : sp;
         cp = int_sqrt((64'd1 << 56) - mag * mag);
         e.pitch = round_q13(vector_angle(sp, cp));
         e.clamped = 1'b0;
      end
      e.yaw = round_q13(vector_angle(yy, yx));
      return e;
   endfunction

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(0, 9))
         0: return 16'sh7FFF;
         1: return 16'sh8000;
         2: return 16'sd0;
         default: return 16'($urandom);
      endcase
   endfunction

   // Random unit quaternion with a random scale error
   function automatic quat_type rand_unit();
      real v[4], n, s;
      quat_type q;
      n = 0.0;
      for (int i = 0; i < 4; i++) begin
         v[i] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
         n += v[i] * v[i];
      end
      if (n < 1e-6) begin
         v[0] = 1.0; n = 1.0;
      end
      s = 16384.0 * (0.97 + $urandom_range(0, 60) / 1000.0) / $sqrt(n);
      q.a = 16'($rtoi(v[0] * s)); q.b = 16'($rtoi(v[1] * s));
      q.c = 16'($rtoi(v[2] * s)); q.d = 16'($rtoi(v[3] * s));
      return q;
   endfunction

   function automatic quat_type mk(int a, int b, int c, int d);
      quat_type q;
      q.a = 16'(a); q.b = 16'(b); q.c = 16'(c); q.d = 16'(d);
      return q;
   endfunction

   // Drive request transactions from the queue
   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (reset) begin
         req_chan.valid  <= 1'b0;
         req_chan.comp_a <= '0;
         req_chan.comp_b <= '0;
         req_chan.comp_c <= '0;
         req_chan.comp_d <= '0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_quats.size() != 0 && !hold_send &&
             (src_quiet || $urandom_range(0, 99) >= 20)) begin
            req_chan.valid <= 1'b1;
            {req_chan.comp_a, req_chan.comp_b, req_chan.comp_c, req_chan.comp_d}
               <= pending_quats.pop_front();
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Predict on each accepted request
   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready) begin
         expected_angles.push_back(predict_euler(mk(req_chan.comp_a, req_chan.comp_b,
                                                    req_chan.comp_c, req_chan.comp_d)));
         sent <= sent + 1;
      end
   end

   // Drive result ready and check each result transaction
   always @(posedge clock) begin
      euler_type exp_e;
      euler_type got;
      rsp_chan.ready <= reset ? 1'b0 : (sink_quiet || $urandom_range(0, 99) >= 20);
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = {rsp_chan.roll_angle, rsp_chan.pitch_angle, rsp_chan.yaw_angle,
                rsp_chan.pitch_clamped};
         received <= received + 1;
         if (expected_angles.size() == 0) begin
            $display("%0t: unexpected result, actual %p", $time, got);
            errors++;
         end else begin
            exp_e = expected_angles.pop_front();
            if (got.clamped) clamp_count++;
            if (got.roll !== exp_e.roll) begin
               $display("%0t: roll expected %0d actual %0d", $time, exp_e.roll, got.roll);
               errors++;
            end
            if (got.pitch !== exp_e.pitch) begin
               $display("%0t: pitch expected %0d actual %0d", $time, exp_e.pitch, got.pitch);
               errors++;
            end
            if (got.yaw !== exp_e.yaw) begin
               $display("%0t: yaw expected %0d actual %0d", $time, exp_e.yaw, got.yaw);
               errors++;
            end
            if (got.clamped !== exp_e.clamped) begin
               $display("%0t: clamp expected %0b actual %0b", $time, exp_e.clamped,
                        got.clamped);
               errors++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      if (cycle > LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle);
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: identity, extremes, zero operands, positive pitch clamp
      pending_quats.push_back(mk(16384, 0, 0, 0));
      pending_quats.push_back(mk(0, 0, 0, 0));
      pending_quats.push_back(mk(32767, 32767, 32767, 32767));
      pending_quats.push_back(mk(-32768, -32768, -32768, -32768));
      pending_quats.push_back(mk(32767, -32768, 32767, -32768));
      pending_quats.push_back(mk(-32768, 32767, -32768, 32767));
      pending_quats.push_back(mk(11585, 0, 11585, 0));
      pending_quats.push_back(mk(11585, 0, -11585, 0));
      pending_quats.push_back(mk(11586, 0, 11586, 0));
      pending_quats.push_back(mk(11584, 0, 11584, 0));
      pending_quats.push_back(mk(0, 16384, 0, 0));
      pending_quats.push_back(mk(0, 0, 16384, 0));
      pending_quats.push_back(mk(0, 0, 0, 16384));
      pending_quats.push_back(mk(11585, 11585, 0, 0));
      pending_quats.push_back(mk(11585, 0, 0, -11585));
      pending_quats.push_back(mk(0, 11585, 11585, 0));
      pending_quats.push_back(mk(8192, 8192, 8192, 8192));
      pending_quats.push_back(mk(-8192, 8192, -8192, 8192));
      pending_quats.push_back(mk(1, -1, 1, -1));
      pending_quats.push_back(mk(-32768, 0, 0, 0));
      wait (pending_quats.size() == 0);

      // Pause the sender until everything has drained
      hold_send = 1'b1;
      wait (expected_angles.size() == 0 && !req_chan.valid);
      hold_send = 1'b0;

      // Random, with a stretch of no idling in the middle
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 400) begin
            wait (pending_quats.size() == 0);
            src_quiet = 1'b1;
            sink_quiet = 1'b1;
         end
         if (i == 650) begin
            wait (pending_quats.size() == 0);
            src_quiet = 1'b0;
            sink_quiet = 1'b0;
         end
         if ($urandom_range(0, 99) < 75)
            pending_quats.push_back(rand_unit());
         else
            pending_quats.push_back(mk(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
      end
      wait (pending_quats.size() == 0);
      wait (expected_angles.size() == 0 && !req_chan.valid);
      repeat (LATENCY + 10) @(posedge clock);

      $display("Converted %0d quaternions, checked %0d results, %0d with pitch clamped.",
               sent, received, clamp_count);
      if (errors == 0 && expected_angles.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
